>>> rtl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and codes for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP = 2'd2;

    // reset values of the thresholds
    localparam logic [CNT_W-1:0] RST_LONG_TAP   = 16'd500;
    localparam logic [CNT_W-1:0] RST_HOLD       = 16'd1000;
    localparam logic [CNT_W-1:0] RST_DOUBLE_TAP = 16'd300;

    // event codes
    localparam logic [2:0] EV_PRESS   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_TAP     = 3'd2;
    localparam logic [2:0] EV_DOUBLE  = 3'd3;
    localparam logic [2:0] EV_LONG    = 3'd4;
    localparam logic [2:0] EV_HOLD    = 3'd5;

    // input action codes
    localparam logic ACT_LEVEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [2:0] button;
        logic       level;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_button;
        logic [2:0] event_code;
        logic       last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_upd;
        logic       press_upd;
        logic       rel_upd;
        logic       idx_inc;
        logic       emit;
        logic       flush;
        logic [2:0] code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;
        logic level;
        logic held;
        logic fire_long;
        logic fire_hold;
        logic tap_ok;
        logic dbl;
        logic last_idx;
        logic can_emit;
        logic can_flush;
    } sts_t;

endpackage

>>> rtl/bgd_ctrl.sv
// ----------------------------------------------------------------------------
// bgd_ctrl
// Sequencer: walks the button scan on ticks and the event series of a
// level change, issuing update and emit commands to the datapath.
// ----------------------------------------------------------------------------
module bgd_ctrl
    import bgd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic in_tick,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_HOLD_EV = 7'b0000100,
        S_LEVEL   = 7'b0001000,
        S_TAP     = 7'b0010000,
        S_DBL     = 7'b0100000,
        S_FLUSH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = in_tick ? S_SCAN : S_LEVEL;
                end
            end
            S_SCAN: begin
                if (!(sts.fire_long || sts.fire_hold) || sts.can_emit) begin
                    cmd.scan_upd = 1'b1;
                    cmd.emit     = sts.fire_long || sts.fire_hold;
                    cmd.code     = sts.fire_long ? EV_LONG : EV_HOLD;
                    if (sts.fire_long && sts.fire_hold) begin
                        state_next = S_HOLD_EV;
                    end else if (sts.last_idx) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_HOLD_EV: begin
                if (sts.can_emit) begin
                    cmd.emit = 1'b1;
                    cmd.code = EV_HOLD;
                    if (sts.last_idx) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_LEVEL: begin
                if (!sts.in_range || (sts.level == sts.held)) begin
                    state_next = S_IDLE;
                end else if (sts.can_emit) begin
                    cmd.emit = 1'b1;
                    if (sts.level) begin
                        cmd.press_upd = 1'b1;
                        cmd.code      = EV_PRESS;
                        state_next    = S_FLUSH;
                    end else begin
                        cmd.rel_upd = 1'b1;
                        cmd.code    = EV_RELEASE;
                        state_next  = sts.tap_ok ? S_TAP : S_FLUSH;
                    end
                end
            end
            S_TAP: begin
                if (sts.can_emit) begin
                    cmd.emit   = 1'b1;
                    cmd.code   = EV_TAP;
                    state_next = sts.dbl ? S_DBL : S_FLUSH;
                end
            end
            S_DBL: begin
                if (sts.can_emit) begin
                    cmd.emit   = 1'b1;
                    cmd.code   = EV_DOUBLE;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (sts.can_flush) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bgd_btn_dp.sv
// ----------------------------------------------------------------------------
// bgd_btn_dp
// Per-button state, threshold registers and the update logic for the
// button selected by the scan index.
// ----------------------------------------------------------------------------
module bgd_btn_dp
    import bgd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  in_item_t             s_item,
    input  cmd_t                 cmd,
    output logic                 in_range,
    output logic                 level,
    output logic                 held,
    output logic                 fire_long,
    output logic                 fire_hold,
    output logic                 tap_ok,
    output logic                 dbl,
    output logic                 last_idx,
    output logic [2:0]           cur_button
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [CNT_W-1:0] long_tap_reg, hold_reg, double_tap_reg;

    logic [IDX_W-1:0] cur_reg;
    logic             rng_reg;
    logic             lvl_reg;
    logic             dbl_reg;

    logic [NUM_BUTTONS-1:0] held_reg;
    logic [NUM_BUTTONS-1:0] long_done_reg;
    logic [NUM_BUTTONS-1:0] hold_done_reg;
    logic [NUM_BUTTONS-1:0] tap_pend_reg;
    logic [CNT_W-1:0]       press_ticks_reg [NUM_BUTTONS];
    logic [CNT_W-1:0]       since_tap_reg   [NUM_BUTTONS];

    logic             b_held, b_ld, b_hd, b_tp;
    logic [CNT_W-1:0] b_pt, b_st;
    logic             tp_next;
    logic [CNT_W-1:0] st_next, pt_next;
    logic             dbl_next;

    // selected button
    assign b_held = held_reg[cur_reg];
    assign b_ld   = long_done_reg[cur_reg];
    assign b_hd   = hold_done_reg[cur_reg];
    assign b_tp   = tap_pend_reg[cur_reg];
    assign b_pt   = press_ticks_reg[cur_reg];
    assign b_st   = since_tap_reg[cur_reg];

    // tick update of the selected button
    always_comb begin
        tp_next = b_tp;
        st_next = b_st;
        if (b_tp) begin
            if (b_st == CNT_MAX) begin
                tp_next = 1'b0;
            end else begin
                st_next = b_st + 1'b1;
            end
        end
        pt_next   = (b_pt == CNT_MAX) ? b_pt : b_pt + 1'b1;
        fire_long = b_held && !b_ld && (pt_next >= long_tap_reg);
        fire_hold = b_held && !b_hd && (pt_next >= hold_reg);
        if (fire_long || fire_hold) begin
            tp_next = 1'b0;
        end
    end

    // double tap check on release
    assign dbl_next = b_tp && (b_st <= double_tap_reg);

    assign in_range   = rng_reg;
    assign level      = lvl_reg;
    assign held       = b_held;
    assign tap_ok     = !b_ld && !b_hd;
    assign dbl        = dbl_reg;
    assign last_idx   = (cur_reg == IDX_W'(NUM_BUTTONS - 1));
    assign cur_button = 3'(cur_reg);

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_tap_reg   <= RST_LONG_TAP;
            hold_reg       <= RST_HOLD;
            double_tap_reg <= RST_DOUBLE_TAP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LONG_TAP:   long_tap_reg   <= cfg_wr_data;
                CFG_HOLD:       hold_reg       <= cfg_wr_data;
                CFG_DOUBLE_TAP: double_tap_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // latched item and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            rng_reg <= 1'b0;
            lvl_reg <= 1'b0;
            dbl_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                cur_reg <= (s_item.action == ACT_TICK) ? '0 : IDX_W'(s_item.button);
                rng_reg <= 32'(s_item.button) < 32'(NUM_BUTTONS);
                lvl_reg <= s_item.level;
            end else if (cmd.idx_inc) begin
                cur_reg <= cur_reg + 1'b1;
            end
            if (cmd.rel_upd) begin
                dbl_reg <= dbl_next;
            end
        end
    end

    // per-button state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            long_done_reg <= '0;
            hold_done_reg <= '0;
            tap_pend_reg  <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_ticks_reg[i] <= '0;
                since_tap_reg[i]   <= '0;
            end
        end else if (cmd.scan_upd) begin
            tap_pend_reg[cur_reg]  <= tp_next;
            since_tap_reg[cur_reg] <= st_next;
            if (b_held) begin
                press_ticks_reg[cur_reg] <= pt_next;
                long_done_reg[cur_reg]   <= b_ld || fire_long;
                hold_done_reg[cur_reg]   <= b_hd || fire_hold;
            end
        end else if (cmd.press_upd) begin
            held_reg[cur_reg]        <= 1'b1;
            long_done_reg[cur_reg]   <= 1'b0;
            hold_done_reg[cur_reg]   <= 1'b0;
            press_ticks_reg[cur_reg] <= '0;
        end else if (cmd.rel_upd) begin
            held_reg[cur_reg] <= 1'b0;
            if (!b_ld && !b_hd) begin
                tap_pend_reg[cur_reg] <= !dbl_next;
                if (!dbl_next) begin
                    since_tap_reg[cur_reg] <= '0;
                end
            end
        end
    end

endmodule

>>> rtl/bgd_out.sv
// ----------------------------------------------------------------------------
// bgd_out
// Result side: one event is held back until the next one or the end of
// the item shows whether it is the last, then moves to the output register.
// ----------------------------------------------------------------------------
module bgd_out
    import bgd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      cmd,
    input  logic [2:0] ev_button,
    output logic      can_emit,
    output logic      can_flush,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic       hb_valid_reg;
    logic [2:0] hb_button_reg;
    logic [2:0] hb_code_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic       out_free;

    assign out_free  = !out_valid_reg || m_ready;
    assign can_emit  = !hb_valid_reg || out_free;
    assign can_flush = can_emit;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // holdback and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if ((cmd.emit || cmd.flush) && hb_valid_reg) begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.emit) begin
                hb_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                hb_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the held-back and output beats
    always_ff @(posedge aclk) begin
        if ((cmd.emit || cmd.flush) && hb_valid_reg) begin
            out_item_reg.event_button <= hb_button_reg;
            out_item_reg.event_code   <= hb_code_reg;
            out_item_reg.last         <= cmd.flush;
        end
        if (cmd.emit) begin
            hb_button_reg <= ev_button;
            hb_code_reg   <= cmd.code;
        end
    end

endmodule

>>> rtl/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// Turns button level changes and millisecond ticks into gesture events.
// ----------------------------------------------------------------------------
// Each input beat is a level change of one button or a one millisecond tick.
// A level change is either ignored, or is a press, or a release followed by
// tap and double tap events; its events are issued one per cycle while the
// output side can take them. A tick walks the per-button state one button
// per cycle while the output side can take events, passing through an extra
// hold event state for each button that fires long tap and hold on the same
// tick. Events leave through an output register, one per cycle while m_ready
// is high; the last one of an item is held back until the item ends so it
// can carry the last flag. A full output register stalls the sequencer.
// ----------------------------------------------------------------------------
module button_gesture_detector
    import bgd_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    cmd_t       cmd;
    sts_t       sts;
    logic [2:0] cur_button;

    bgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_tick (s_item.action == ACT_TICK),
        .sts     (sts),
        .cmd     (cmd)
    );

    bgd_btn_dp #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .in_range    (sts.in_range),
        .level       (sts.level),
        .held        (sts.held),
        .fire_long   (sts.fire_long),
        .fire_hold   (sts.fire_hold),
        .tap_ok      (sts.tap_ok),
        .dbl         (sts.dbl),
        .last_idx    (sts.last_idx),
        .cur_button  (cur_button)
    );

    bgd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .ev_button (cur_button),
        .can_emit  (sts.can_emit),
        .can_flush (sts.can_flush),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

>>> rtl/bgd_checker.sv
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module bgd_checker
    import bgd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // only defined event codes leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.event_code <= EV_HOLD))
        else $error("undefined event code");

    // a press is always the only event of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.event_code == EV_PRESS) |-> m_item.last)
        else $error("press event not marked last");

    // ready is low in the cycle after an item is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accept");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
